### rtl/iba_pkg.sv
`default_nettype none

package iba_pkg;

  // default sizes
  localparam int DEF_NUM_BLOCKS      = 128;
  localparam int DEF_TABLE_SLOTS     = 32;
  localparam int DEF_BLOCKS_PER_FILE = 32;

  localparam int BLOCK_W   = 8;
  localparam int MAXDATA_W = 6;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 5;

  localparam logic [MAXDATA_W-1:0] MAX_DATA_RESET = 6'd20;

  // result codes
  localparam logic [STATUS_W-1:0] STAT_OK            = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_COUNT     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL          = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_INDEX_INVALID = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_INDEX_TAKEN   = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_DATA_INVALID  = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_DATA_TAKEN    = 3'd6;

  // packed so that status sits in the low bits
  typedef struct packed {
    logic [SLOT_W-1:0]   file_slot;
    logic [BLOCK_W-1:0]  bad_block;
    logic [STATUS_W-1:0] status;
  } res_t;

  localparam int RES_W = $bits(res_t);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_COMMIT_IDX,
    S_COMMIT_DATA,
    S_FIN
  } iba_state_t;

endpackage

`default_nettype wire

### rtl/indexed_block_allocator.sv
// Indexed block allocator with a free-block bitmap.
// Input stream: one request is a run of block numbers. in_tuser marks the
// index block that opens the request, in_tlast marks the final data block.
// Each item is accepted in S_IDLE, which issues the bitmap read, and checked
// in S_CHECK against the registered read data; no new item is taken until
// that check is done. A data item outside an open request is dropped.
// At the end of a request one result goes out: a failing request goes from
// the check straight to S_FIN, a successful one first passes S_COMMIT_IDX and
// S_COMMIT_DATA, as the commit walks the pending buffer one block per cycle
// through the bitmap write port. The result waits in res_r, then in an output
// register that drives out_tvalid; the core finishes its next request only
// once that register frees up, so a stalled receiver backs up to in_tready.
// cfg channel writes max_data_blocks (reset 20), always ready; write it only
// while the block is idle. After reset the bitmap is cleared block by block in
// S_CLEAR with in_tready low.
`default_nettype none

module indexed_block_allocator #(
  parameter int NUM_BLOCKS      = iba_pkg::DEF_NUM_BLOCKS,
  parameter int TABLE_SLOTS     = iba_pkg::DEF_TABLE_SLOTS,
  parameter int BLOCKS_PER_FILE = iba_pkg::DEF_BLOCKS_PER_FILE
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // block_number [7:0]
  input  wire logic [iba_pkg::BLOCK_W-1:0]     in_tdata,
  // first_item [0]
  input  wire logic                            in_tuser,
  input  wire logic                            in_tlast,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // status [2:0], bad_block [10:3], file_slot [15:11]
  output logic [iba_pkg::RES_W-1:0]            out_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [iba_pkg::MAXDATA_W-1:0]   cfg_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready
);

  import iba_pkg::*;

  logic [MAXDATA_W-1:0] max_data_r, max_data_nxt;
  logic                 res_valid, res_ready;
  res_t                 res;
  res_t                 out_res;

  assign cfg_ready    = 1'b1;
  assign max_data_nxt = (cfg_valid && cfg_ready) ? cfg_data : max_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_data_r <= MAX_DATA_RESET;
    end else begin
      max_data_r <= max_data_nxt;
    end
  end

  iba_core #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .TABLE_SLOTS     (TABLE_SLOTS),
    .BLOCKS_PER_FILE (BLOCKS_PER_FILE)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_data  (max_data_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_block  (in_tdata),
    .in_first  (in_tuser),
    .in_last   (in_tlast),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  iba_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign out_res = out_tdata;

  // no block number reported for count or table errors
  a_no_bad_block : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_res.status == STAT_OK || out_res.status == STAT_BAD_COUNT ||
                   out_res.status == STAT_FULL) |-> out_res.bad_block == '0)
    else $error("bad_block set on a result without a block error");

  // a slot is handed out only on success
  a_slot_on_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_res.status != STAT_OK |-> out_res.file_slot == '0)
    else $error("file_slot set on a failed request");

  // core result holds until the output register takes it
  a_res_hold : assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("core result changed while waiting");

endmodule

`default_nettype wire

### rtl/iba_ram.sv
`default_nettype none

module iba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### rtl/iba_core.sv
`default_nettype none

module iba_core #(
  parameter int NUM_BLOCKS      = 128,
  parameter int TABLE_SLOTS     = 32,
  parameter int BLOCKS_PER_FILE = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic [5:0]   max_data,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_block,
  input  wire logic         in_first,
  input  wire logic         in_last,
  output logic              res_valid,
  input  wire logic         res_ready,
  output iba_pkg::res_t     res
);

  import iba_pkg::*;

  localparam int BW  = $clog2(NUM_BLOCKS);
  localparam int PW  = (BLOCKS_PER_FILE > 1) ? $clog2(BLOCKS_PER_FILE) : 1;
  localparam int CW  = $clog2(BLOCKS_PER_FILE + 2);
  localparam int SW  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int TW  = $clog2(TABLE_SLOTS + 1);
  localparam int TD  = TABLE_SLOTS * BLOCKS_PER_FILE;
  localparam int TAW = (TD > 1) ? $clog2(TD) : 1;

  iba_state_t state_r, state_nxt;
  logic [BW-1:0]       clr_r, clr_nxt;
  logic [BLOCK_W-1:0]  blk_r, blk_nxt;
  logic                first_r, first_nxt;
  logic                last_r, last_nxt;
  logic                open_r, open_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [BW-1:0]       index_r, index_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt;
  logic [BLOCK_W-1:0]  err_blk_r, err_blk_nxt;
  logic [TW-1:0]       total_r, total_nxt;
  logic [TAW-1:0]      base_r, base_nxt;
  logic [PW-1:0]       step_r, step_nxt;
  res_t                res_r, res_nxt;

  logic          used_we, used_re, used_wdata, used_rdata;
  logic [BW-1:0] used_waddr, used_raddr;
  logic          pend_we, pend_re;
  logic [PW-1:0] pend_waddr, pend_raddr;
  logic [BW-1:0] pend_wdata, pend_rdata;
  logic          dir_we, tbl_we;

  iba_ram #(.WIDTH(1), .DEPTH(NUM_BLOCKS)) u_used_map (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .re    (used_re),
    .raddr (used_raddr),
    .rdata (used_rdata)
  );

  iba_ram #(.WIDTH(BW), .DEPTH(BLOCKS_PER_FILE)) u_pending (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .re    (pend_re),
    .raddr (pend_raddr),
    .rdata (pend_rdata)
  );

  // file table: index block and count per slot
  iba_ram #(.WIDTH(BW + CW), .DEPTH(TABLE_SLOTS)) u_dir (
    .clk   (clk),
    .we    (dir_we),
    .waddr (SW'(total_r)),
    .wdata ({index_r, count_r}),
    .re    (1'b0),
    .raddr ('0),
    .rdata ()
  );

  // file table: data blocks, one row of BLOCKS_PER_FILE per slot
  iba_ram #(.WIDTH(BW), .DEPTH(TD)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (base_r + TAW'(step_r)),
    .wdata (pend_rdata),
    .re    (1'b0),
    .raddr ('0),
    .rdata ()
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      open_r    <= 1'b0;
      count_r   <= '0;
      index_r   <= '0;
      err_r     <= STAT_OK;
      err_blk_r <= '0;
      total_r   <= '0;
      base_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      open_r    <= open_nxt;
      count_r   <= count_nxt;
      index_r   <= index_nxt;
      err_r     <= err_nxt;
      err_blk_r <= err_blk_nxt;
      total_r   <= total_nxt;
      base_r    <= base_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r   <= blk_nxt;
    first_r <= first_nxt;
    last_r  <= last_nxt;
    step_r  <= step_nxt;
    res_r   <= res_nxt;
  end

  always_comb begin
    logic       blk_ok;
    logic       fin;
    logic [6:0] limit;
    state_nxt   = state_r;
    clr_nxt     = clr_r;
    blk_nxt     = blk_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    open_nxt    = open_r;
    count_nxt   = count_r;
    index_nxt   = index_r;
    err_nxt     = err_r;
    err_blk_nxt = err_blk_r;
    total_nxt   = total_r;
    base_nxt    = base_r;
    step_nxt    = step_r;
    res_nxt     = res_r;
    used_we     = 1'b0;
    used_waddr  = index_r;
    used_wdata  = 1'b1;
    used_re     = 1'b0;
    used_raddr  = BW'(in_block);
    pend_we     = 1'b0;
    pend_waddr  = PW'(count_r);
    pend_wdata  = '0;
    pend_re     = 1'b0;
    pend_raddr  = '0;
    dir_we      = 1'b0;
    tbl_we      = 1'b0;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    fin         = 1'b0;
    blk_ok      = ({1'b0, blk_r} < 9'(NUM_BLOCKS));
    limit       = ({1'b0, max_data} > 7'(BLOCKS_PER_FILE)) ? 7'(BLOCKS_PER_FILE)
                                                          : {1'b0, max_data};
    case (state_r)
      S_CLEAR: begin
        used_we    = 1'b1;
        used_waddr = clr_r;
        used_wdata = 1'b0;
        if (clr_r == BW'(NUM_BLOCKS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          blk_nxt   = in_block;
          first_nxt = in_first;
          last_nxt  = in_last;
          used_re   = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = S_IDLE;
        if (first_r) begin
          open_nxt    = 1'b1;
          count_nxt   = '0;
          err_nxt     = STAT_OK;
          err_blk_nxt = '0;
          index_nxt   = '0;
          if (!blk_ok) begin
            err_nxt     = STAT_INDEX_INVALID;
            err_blk_nxt = blk_r;
          end else if (used_rdata) begin
            err_nxt     = STAT_INDEX_TAKEN;
            err_blk_nxt = blk_r;
          end else begin
            index_nxt = BW'(blk_r);
          end
          fin = last_r;
        end else if (open_r) begin
          if (count_r < CW'(BLOCKS_PER_FILE)) begin
            pend_we    = 1'b1;
            pend_wdata = blk_ok ? BW'(blk_r) : '0;
            if (err_r == STAT_OK) begin
              if (!blk_ok) begin
                err_nxt     = STAT_DATA_INVALID;
                err_blk_nxt = blk_r;
              end else if (used_rdata) begin
                err_nxt     = STAT_DATA_TAKEN;
                err_blk_nxt = blk_r;
              end
            end
          end
          // saturate just past the largest limit
          if (count_r != CW'(BLOCKS_PER_FILE + 1)) begin
            count_nxt = count_r + 1'b1;
          end
          fin = last_r;
        end
        if (fin) begin
          open_nxt  = 1'b0;
          state_nxt = S_FIN;
          res_nxt   = '0;
          if ((count_nxt == '0) || (7'(count_nxt) > limit)) begin
            res_nxt.status = STAT_BAD_COUNT;
          end else if (total_r >= TW'(TABLE_SLOTS)) begin
            res_nxt.status = STAT_FULL;
          end else if (err_nxt != STAT_OK) begin
            res_nxt.status    = err_nxt;
            res_nxt.bad_block = err_blk_nxt;
          end else begin
            state_nxt = S_COMMIT_IDX;
          end
        end
      end
      S_COMMIT_IDX: begin
        used_we    = 1'b1;
        used_waddr = index_r;
        dir_we     = 1'b1;
        pend_re    = 1'b1;
        pend_raddr = '0;
        step_nxt   = '0;
        state_nxt  = S_COMMIT_DATA;
      end
      S_COMMIT_DATA: begin
        // one buffered block per cycle into the map and the table row
        used_we    = 1'b1;
        used_waddr = pend_rdata;
        tbl_we     = 1'b1;
        if (CW'(step_r) + CW'(1) == count_r) begin
          res_nxt.status    = STAT_OK;
          res_nxt.bad_block = '0;
          res_nxt.file_slot = SLOT_W'(total_r);
          total_nxt         = total_r + 1'b1;
          base_nxt          = base_r + TAW'(BLOCKS_PER_FILE);
          state_nxt         = S_FIN;
        end else begin
          pend_re    = 1'b1;
          pend_raddr = PW'(step_r + 1'b1);
          step_nxt   = PW'(step_r + 1'b1);
        end
      end
      S_FIN: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

`default_nettype wire

### rtl/iba_out_stage.sv
`default_nettype none

module iba_out_stage (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         res_valid,
  output logic                              res_ready,
  input  wire iba_pkg::res_t                res,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [iba_pkg::RES_W-1:0]         out_tdata
);

  import iba_pkg::*;

  logic out_valid_r, out_valid_nxt;
  res_t out_data_r, out_data_nxt;

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_data_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
